// ----- hw/rtl/esc_pkg.sv -----
// esc_pkg: shared types, register indexes and fixed-point helpers for the
// environmental sensor compensation block. Depends on nothing.
`timescale 1ns / 1ps
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } esc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic               press_div_zero;
  } esc_out_t;

  // Entry handed from the temperature front to the pressure/humidity back.
  typedef struct packed {
    logic [31:0] tf;
    logic [31:0] temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } esc_qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } esc_qstat_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [47:0] p9_hum;
    logic [39:0] hum_b;
  } esc_coef_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFFS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COEFFS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9_HUM_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEFFS_B   = 3'd4;

  localparam int unsigned ESC_QDEPTH  = 8;
  // Divider: one input stage, one stage per quotient bit, one sign stage.
  localparam int unsigned ESC_DIV_LAT = 66;

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

endpackage

// ----- hw/rtl/esc_front.sv -----
// esc_front: accepts raw readings and derives the fine temperature and the
// temperature result over three stages. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  esc_pkg::esc_in_t    in_item,
  input  esc_pkg::esc_qstat_t q_stat,
  input  esc_pkg::esc_coef_t  coef,
  output logic                accept,
  output logic                push,
  output esc_pkg::esc_qent_t  push_ent
);
  import esc_pkg::*;

  logic [3:0]  vld_r;
  esc_in_t     s0_r, s1_r, s2_r, s3_r;
  logic [31:0] pa1_r, dd1_r, a2_r, b2_r, tf3_r;
  logic [31:0] t1, t2, t3, at32, dif;

  assign accept = in_valid && !q_stat.full;
  assign t1     = 32'(coef.temp[15:0]);
  assign t2     = sx16_32(coef.temp[31:16]);
  assign t3     = sx16_32(coef.temp[47:32]);
  assign at32   = 32'(s0_r.raw_temp);
  assign dif    = (at32 >> 4) - t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    s0_r  <= in_item;
    s1_r  <= s0_r;
    s2_r  <= s1_r;
    s3_r  <= s2_r;
    pa1_r <= ((at32 >> 3) - (t1 << 1)) * t2;
    dd1_r <= dif * dif;
    a2_r  <= asr32(pa1_r, 11);
    b2_r  <= asr32(dd1_r, 12) * t3;
    tf3_r <= a2_r + asr32(b2_r, 14);
  end

  assign push               = vld_r[3];
  assign push_ent.tf        = tf3_r;
  assign push_ent.temp      = asr32(tf3_r * 32'd5 + 32'd128, 8);
  assign push_ent.raw_press = s3_r.raw_press;
  assign push_ent.raw_hum   = s3_r.raw_hum;

endmodule

// ----- hw/rtl/esc_queue.sv -----
// esc_queue: short queue between front and back, with a reservation count
// so that items in flight in the front always find a slot. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_queue #(
  parameter int unsigned DEPTH = esc_pkg::ESC_QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                reserve,
  input  logic                push,
  input  esc_pkg::esc_qent_t  push_ent,
  input  logic                pop,
  output esc_pkg::esc_qent_t  head,
  output esc_pkg::esc_qstat_t stat
);
  import esc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  esc_qent_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r, resv_r;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head       = mem_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (resv_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
      resv_r <= '0;
    end else begin
      if (push) wr_r <= inc(wr_r);
      if (pop)  rd_r <= inc(rd_r);
      cnt_r  <= cnt_r + CW'(push) - CW'(pop);
      resv_r <= resv_r + CW'(reserve) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_ent;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CW'(DEPTH)))
    else $error("queue written while holding DEPTH entries");
  a_resv_covers: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= resv_r)
    else $error("stored count exceeds reservations");
  a_pop_release: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !reserve) |=> (resv_r == $past(resv_r) - 1'b1))
    else $error("pop did not release a reservation");

endmodule

// ----- hw/rtl/esc_mul64.sv -----
// esc_mul64: low 64 bits of a 64 x 64 product, from three 32 x 32 partial
// products in a first stage and their sum in a second. No dependencies.
`timescale 1ns / 1ps
module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] ll_r, p_r;
  logic [31:0] lh_r, hl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(a[31:0]) * 64'(b[31:0]);
      lh_r <= a[31:0] * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'b0};
    end
  end

  assign p = p_r;

endmodule

// ----- hw/rtl/esc_div64.sv -----
// esc_div64: pipelined signed 64-bit division truncating toward zero, one
// quotient bit per stage. Imports esc_pkg; the stage count is its own NB.
`timescale 1ns / 1ps
module esc_div64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);
  import esc_pkg::*;

  localparam int unsigned NB = 64;

  logic [63:0] rem_r [NB+1];
  logic [63:0] nq_r  [NB+1];
  logic [63:0] md_r  [NB+1];
  logic        neg_r [NB+1];
  logic [63:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num[63] ? (64'd0 - num) : num;
      md_r[0]  <= den[63] ? (64'd0 - den) : den;
      neg_r[0] <= num[63] ^ den[63];
      q_r      <= neg_r[NB] ? (64'd0 - nq_r[NB]) : nq_r[NB];
    end
  end

  for (genvar i = 1; i <= NB; i++) begin : g_step
    logic [63:0] trial;
    logic        ge;
    assign trial = {rem_r[i-1][62:0], nq_r[i-1][63]};
    assign ge    = (trial >= md_r[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (trial - md_r[i-1]) : trial;
        nq_r[i]  <= {nq_r[i-1][62:0], ge};
        md_r[i]  <= md_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  assign quo = q_r;

endmodule

// ----- hw/rtl/esc_back.sv -----
// esc_back: lock-step pipeline for pressure (64-bit, with divider) and
// humidity (32-bit), plus the output register. Depends on esc_pkg,
// esc_mul64 and esc_div64.
`timescale 1ns / 1ps
module esc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  esc_pkg::esc_qent_t  head,
  input  esc_pkg::esc_qstat_t q_stat,
  input  esc_pkg::esc_coef_t  coef,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output esc_pkg::esc_out_t   out_item
);
  import esc_pkg::*;

  localparam int unsigned DIV_IN = 8;
  localparam int unsigned QS     = DIV_IN + ESC_DIV_LAT;
  localparam int unsigned LS     = QS + 5;

  logic adv;
  logic [LS:0] vld_r;
  logic        out_valid_r;
  esc_out_t    out_item_r;

  logic [31:0] temp_r [LS+1];
  logic [31:0] tf0_r;
  logic [19:0] ap_r [6];
  logic [15:0] ah_r [2];
  logic        dz_r [DIV_IN+1:LS];
  logic [16:0] hum_r [11:LS];

  // pressure coefficients
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = 64'(coef.press_a[15:0]);
  assign p2 = sx16_64(coef.press_a[31:16]);
  assign p3 = sx16_64(coef.press_a[47:32]);
  assign p4 = sx16_64(coef.press_a[63:48]);
  assign p5 = sx16_64(coef.press_b[15:0]);
  assign p6 = sx16_64(coef.press_b[31:16]);
  assign p7 = sx16_64(coef.press_b[47:32]);
  assign p8 = sx16_64(coef.press_b[63:48]);
  assign p9 = sx16_64(coef.p9_hum[15:0]);

  // humidity coefficients
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign h1 = 32'(coef.p9_hum[23:16]);
  assign h2 = sx16_32(coef.p9_hum[39:24]);
  assign h3 = 32'(coef.p9_hum[47:40]);
  assign h4 = sx16_32(coef.hum_b[15:0]);
  assign h5 = sx16_32(coef.hum_b[31:16]);
  assign h6 = sx8_32(coef.hum_b[39:32]);

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !q_stat.empty;

  // pressure datapath
  logic [63:0] w1_0, pa2, pb2, pc2, pd4, pe4, pf7, pg8, q74, ph76, pi76, pj78;
  logic [63:0] b_d3_r, b_d4_r, c_d3_r, c_d4_r, w2_5_r, x5_r, num6_r, dv8_r;
  logic [63:0] xs74, xs75_r, xs76_r, q75_r, q76_r, q77_r, q78_r, i77_r, i78_r;
  logic [63:0] sum79_r, pfin;
  logic [31:0] press;

  assign w1_0 = {{32{tf0_r[31]}}, tf0_r} - 64'd128000;
  assign xs74 = asr64(q74, 13);

  esc_mul64 u_mul_a (.clk, .en(adv), .a(w1_0),   .b(w1_0),     .p(pa2));
  esc_mul64 u_mul_b (.clk, .en(adv), .a(w1_0),   .b(p5),       .p(pb2));
  esc_mul64 u_mul_c (.clk, .en(adv), .a(w1_0),   .b(p2),       .p(pc2));
  esc_mul64 u_mul_d (.clk, .en(adv), .a(pa2),    .b(p6),       .p(pd4));
  esc_mul64 u_mul_e (.clk, .en(adv), .a(pa2),    .b(p3),       .p(pe4));
  esc_mul64 u_mul_f (.clk, .en(adv), .a(x5_r),   .b(p1),       .p(pf7));
  esc_mul64 u_mul_g (.clk, .en(adv), .a(num6_r), .b(64'd3125), .p(pg8));
  esc_mul64 u_mul_h (.clk, .en(adv), .a(p9),     .b(xs74),     .p(ph76));
  esc_mul64 u_mul_i (.clk, .en(adv), .a(p8),     .b(q74),      .p(pi76));
  esc_mul64 u_mul_j (.clk, .en(adv), .a(ph76),   .b(xs76_r),   .p(pj78));

  esc_div64 u_div (.clk, .en(adv), .num(pg8), .den(dv8_r), .quo(q74));

  assign pfin = asr64(sum79_r, 8) + (p7 << 4);
  always_comb begin
    priority if (dz_r[LS]) press = '0;
    else if (pfin[63])     press = '0;
    else if (|pfin[63:32]) press = 32'hFFFF_FFFF;
    else                   press = pfin[31:0];
  end

  // humidity datapath
  logic [31:0] v0, m1_1_r, m2_1_r, m3_1_r, ha, t2_r, u2_r, m4_3_r, b4_r;
  logic [31:0] m5_5_r, b2_6_r, m6_7_r, d8_r, v8_r, m7_9_r, v9_r, m8_10_r, v10_r;
  logic [31:0] hv, hcl;
  logic [31:0] a_d_r [2:6];

  assign v0 = tf0_r - 32'd76800;
  assign ha = (32'(ah_r[1]) << 14) - (h4 << 20) - m1_1_r + 32'd16384;
  assign hv = v10_r - asr32(m8_10_r, 4);
  always_comb begin
    priority if (hv[31])          hcl = '0;
    else if (hv > 32'd419430400)  hcl = 32'd419430400;
    else                          hcl = hv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LS-1:0], pop};
      out_valid_r <= vld_r[LS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp_r[0] <= head.temp;
      tf0_r     <= head.tf;
      ap_r[0]   <= head.raw_press;
      ah_r[0]   <= head.raw_hum;
      for (int k = 1; k <= LS; k++) temp_r[k] <= temp_r[k-1];
      for (int k = 1; k < 6; k++) ap_r[k] <= ap_r[k-1];
      ah_r[1] <= ah_r[0];

      // pressure
      b_d3_r <= pb2;
      b_d4_r <= b_d3_r;
      c_d3_r <= pc2;
      c_d4_r <= c_d3_r;
      w2_5_r <= pd4 + (b_d4_r << 17) + (p4 << 35);
      x5_r   <= 64'h0000_8000_0000_0000 + (asr64(pe4, 8) + (c_d4_r << 12));
      num6_r <= ((64'd1048576 - 64'(ap_r[5])) << 31) - w2_5_r;
      dv8_r  <= asr64(pf7, 33);
      dz_r[DIV_IN+1] <= (dv8_r == '0);
      for (int k = DIV_IN + 2; k <= LS; k++) dz_r[k] <= dz_r[k-1];
      xs75_r  <= xs74;
      xs76_r  <= xs75_r;
      q75_r   <= q74;
      q76_r   <= q75_r;
      q77_r   <= q76_r;
      q78_r   <= q77_r;
      i77_r   <= pi76;
      i78_r   <= i77_r;
      sum79_r <= q78_r + asr64(pj78, 25) + asr64(i78_r, 19);

      // humidity
      m1_1_r   <= h5 * v0;
      m2_1_r   <= v0 * h6;
      m3_1_r   <= v0 * h3;
      a_d_r[2] <= asr32(ha, 15);
      t2_r     <= asr32(m3_1_r, 11) + 32'd32768;
      u2_r     <= asr32(m2_1_r, 10);
      for (int k = 3; k <= 6; k++) a_d_r[k] <= a_d_r[k-1];
      m4_3_r   <= u2_r * t2_r;
      b4_r     <= asr32(m4_3_r, 10) + 32'd2097152;
      m5_5_r   <= b4_r * h2;
      b2_6_r   <= asr32(m5_5_r + 32'd8192, 14);
      m6_7_r   <= a_d_r[6] * b2_6_r;
      d8_r     <= asr32(m6_7_r, 15);
      v8_r     <= m6_7_r;
      m7_9_r   <= d8_r * d8_r;
      v9_r     <= v8_r;
      m8_10_r  <= asr32(m7_9_r, 7) * h1;
      v10_r    <= v9_r;
      hum_r[11] <= hcl[28:12];
      for (int k = 12; k <= LS; k++) hum_r[k] <= hum_r[k-1];

      out_item_r.temp_centi     <= temp_r[LS];
      out_item_r.press_q24_8    <= press;
      out_item_r.hum_q22_10     <= hum_r[LS];
      out_item_r.press_div_zero <= dz_r[LS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/env_sensor_compensation.sv -----
// env_sensor_compensation: top level; holds the calibration registers and
// joins front, queue and back. Depends on esc_pkg, esc_front, esc_queue, esc_back.
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+------------------
//   input   | in_valid, in_stall, in_item             | request in| valid & !stall
//   result  | out_valid, out_stall, out_item          | request out| valid & !stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write in | valid & ready
//
// Cycles: one request accepted per clock when nothing stalls; latency runs
// through front, queue and back and is set mostly by the 66-stage divider
// (one input stage, one per quotient bit, one sign stage) on the pressure path.
// Reset: clears the calibration registers to zero and all valid state; no
// clearing pass, first request may follow reset at once.
// Stalls: out_stall freezes the back pipeline while out_valid is high; the front
// keeps running and its requests wait in the queue, in_stall rises once
// QUEUE_DEPTH requests are accepted and not yet taken by the back.
`timescale 1ns / 1ps
module env_sensor_compensation #(
  parameter int unsigned QUEUE_DEPTH = esc_pkg::ESC_QDEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  esc_pkg::esc_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output esc_pkg::esc_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [esc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import esc_pkg::*;

  esc_coef_t  coef_r;
  esc_qstat_t q_stat;
  esc_qent_t  push_ent, head;
  logic       accept, push, pop;

  // Writes are always taken; registers keep only their own width.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP_COEFFS:    coef_r.temp    <= cfg_data[47:0];
        REG_PRESS_COEFFS_A: coef_r.press_a <= cfg_data;
        REG_PRESS_COEFFS_B: coef_r.press_b <= cfg_data;
        REG_PRESS_P9_HUM_A: coef_r.p9_hum  <= cfg_data[47:0];
        REG_HUM_COEFFS_B:   coef_r.hum_b   <= cfg_data[39:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Hold off new requests while every queue slot is spoken for.
  assign in_stall = q_stat.full;

  // Front: fine temperature and temperature result.
  esc_front u_front (
    .clk, .rst_n, .in_valid, .in_item, .q_stat, .coef(coef_r),
    .accept, .push, .push_ent
  );

  // Queue: decouple front from back so each side stalls on its own.
  esc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .reserve(accept), .push, .push_ent, .pop, .head, .stat(q_stat)
  );

  // Back: pressure and humidity, then the output register.
  esc_back u_back (
    .clk, .rst_n, .head, .q_stat, .coef(coef_r), .pop,
    .out_valid, .out_stall, .out_item
  );

endmodule
